[hw/rtl/ae32_pkg.sv]
// ----------------------------------------------------------------------------
// ae32_pkg
// shared types and constants of the 32-bit binary arithmetic encoder
// ----------------------------------------------------------------------------
package ae32_pkg;

  localparam int FREQ_BITS_DEF = 16;

  localparam int REG_W  = 32;  // interval register width
  localparam int RNG_W  = 33;  // interval range high - low + 1
  localparam int CNT_W  = 17;  // cumulative count and total width
  localparam int CL_W   = 16;  // cum_low width
  localparam int PEND_W = 16;  // pending bit counter width

  localparam int MAX_EMIT = 32;
  localparam int EMIT_W   = $clog2(MAX_EMIT + 1);

  localparam logic [REG_W-1:0]  TOP_MASK = 32'hFFFF_FFFF;
  localparam logic [REG_W-1:0]  QUARTER  = 32'h4000_0000;
  localparam logic [PEND_W-1:0] PEND_MAX = 16'hFFFF;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [CL_W-1:0]  cum_low;
    logic [CNT_W-1:0] cum_high;
    logic [CNT_W-1:0] total;
  } in_t;

  typedef struct packed {
    logic              out_bit;
    logic [PEND_W-1:0] follow_count;
    logic              last;
  } out_t;

  function automatic logic [PEND_W-1:0] pend_bump(input logic [PEND_W-1:0] p);
    pend_bump = (p == PEND_MAX) ? p : p + 1'b1;
  endfunction

endpackage

[hw/rtl/ae32_muldiv.sv]
// ----------------------------------------------------------------------------
// ae32_muldiv
// scaled division (a * b) / d, one multiply then one quotient bit per cycle
// ----------------------------------------------------------------------------
module ae32_muldiv import ae32_pkg::*; #(
  parameter int A_W = RNG_W,
  parameter int B_W = CNT_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] op_a,
  input  logic [B_W-1:0] op_b,
  input  logic [B_W-1:0] op_d,
  output logic           done,
  output logic [A_W-1:0] quot
);

  localparam int P_W = A_W + B_W;
  localparam int C_W = $clog2(A_W + 1);
  localparam logic [C_W-1:0] STEPS = C_W'(A_W);

  logic [P_W-1:0] prod;
  logic [B_W-1:0] rem_r;
  logic [A_W-1:0] sh_r;
  logic [B_W-1:0] div_r;
  logic [C_W-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [B_W:0]   rem2;
  logic [B_W:0]   diff;
  logic           ge;

  // b never exceeds d, so the top part of the product is already below d
  assign prod = op_a * op_b;
  assign rem2 = {rem_r, sh_r[A_W-1]};
  assign ge   = (rem2 >= {1'b0, div_r});
  assign diff = rem2 - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == C_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= prod[P_W-1:A_W];
      sh_r  <= prod[A_W-1:0];
      div_r <= op_d;
    end else if (busy_r) begin
      rem_r <= ge ? diff[B_W-1:0] : rem2[B_W-1:0];
      sh_r  <= {sh_r[A_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

[hw/rtl/arithmetic_encoder_32bit.sv]
// ----------------------------------------------------------------------------
// arithmetic_encoder_32bit
// binary arithmetic range encoder with 32-bit high/low interval registers
// ----------------------------------------------------------------------------
//
//   channel   ports                          transfer moves
//   input     in_valid  in_ready  in_data    one symbol (counts) or a flush
//   result    out_valid out_ready out_data   one code bit with follow count
//
// an encode symbol makes two passes through the shared multiply/divide unit
// (a multiply, then the quotient bits, then a hand-off each) and then
// renormalizes the interval one shift at a time
// a symbol with invalid counts is dropped in its transfer cycle, a flush waits
// for a free result register; in_ready is high only while the sequencer is idle
// a stalled result register holds the renormalization loop on its next bit
// rst_n is synchronous, active low; high = all ones, low = pending = zero
// ----------------------------------------------------------------------------
module arithmetic_encoder_32bit import ae32_pkg::*; #(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FLUSH = 3'd1;
  localparam logic [2:0] S_STH   = 3'd2;
  localparam logic [2:0] S_WTH   = 3'd3;
  localparam logic [2:0] S_STL   = 3'd4;
  localparam logic [2:0] S_WTL   = 3'd5;
  localparam logic [2:0] S_REN   = 3'd6;

  // largest legal model total
  localparam logic [31:0] TOT_LIMIT = 32'd1 << FREQ_BITS;

  logic [2:0]        state_r, state_nxt;
  logic [REG_W-1:0]  high_r, high_nxt;
  logic [REG_W-1:0]  low_r, low_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [RNG_W-1:0]  rng_r;
  logic [CNT_W-1:0]  cl_r, ch_r, tot_r;
  logic [RNG_W-1:0]  qh_r;
  logic [EMIT_W-1:0] nemit_r, nemit_nxt;

  // one held code bit, sent once we know whether another bit follows
  logic              hold_v_r, hold_v_nxt;
  logic              hold_bit_r, hold_bit_nxt;
  logic [PEND_W-1:0] hold_cnt_r, hold_cnt_nxt;

  logic              out_v_r, out_v_nxt;
  out_t              out_r, out_nxt;

  logic              in_xfer;
  logic              cnt_bad;
  logic              out_free;
  logic              div_start;
  logic [CNT_W-1:0]  div_b;
  logic              div_done;
  logic [RNG_W-1:0]  div_q;
  logic              emit_c, strad_c;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // invalid counts leave the state untouched
  assign cnt_bad = (in_data.total == '0)
                || ({15'd0, in_data.total} > TOT_LIMIT)
                || (in_data.cum_high > in_data.total)
                || ({1'b0, in_data.cum_low} >= in_data.cum_high);

  // high pass scales by cum_high, low pass by cum_low
  assign div_start = (state_r == S_STH) || (state_r == S_STL);
  assign div_b     = (state_r == S_STH) ? ch_r : cl_r;

  ae32_muldiv #(
    .A_W (RNG_W),
    .B_W (CNT_W)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .op_a  (rng_r),
    .op_b  (div_b),
    .op_d  (tot_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // renormalization cases: both top bits agree, or straddling the middle
  assign emit_c  = !high_r[REG_W-1] || low_r[REG_W-1];
  assign strad_c = (high_r[REG_W-1:REG_W-2] == 2'b10) && (low_r[REG_W-1:REG_W-2] == 2'b01);

  always_comb begin
    state_nxt    = state_r;
    high_nxt     = high_r;
    low_nxt      = low_r;
    pend_nxt     = pend_r;
    nemit_nxt    = nemit_r;
    hold_v_nxt   = hold_v_r;
    hold_bit_nxt = hold_bit_r;
    hold_cnt_nxt = hold_cnt_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_nxt      = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.mode == MODE_FLUSH) begin
            state_nxt = S_FLUSH;
          end else if (!cnt_bad) begin
            state_nxt = S_STH;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_v_nxt            = 1'b1;
          out_nxt.out_bit      = (low_r >= QUARTER);
          out_nxt.follow_count = pend_bump(pend_r);
          out_nxt.last         = 1'b1;
          high_nxt             = TOP_MASK;
          low_nxt              = '0;
          pend_nxt             = '0;
          state_nxt            = S_IDLE;
        end
      end
      S_STH: begin
        state_nxt = S_WTH;
      end
      S_WTH: begin
        if (div_done) begin
          state_nxt = S_STL;
        end
      end
      S_STL: begin
        state_nxt = S_WTL;
      end
      S_WTL: begin
        if (div_done) begin
          high_nxt  = low_r + qh_r[REG_W-1:0] - 1'b1;
          low_nxt   = low_r + div_q[REG_W-1:0];
          nemit_nxt = '0;
          state_nxt = S_REN;
        end
      end
      S_REN: begin
        if ((nemit_r != EMIT_W'(MAX_EMIT)) && emit_c) begin
          // a new bit: the held one goes out first, not marked last
          if (!hold_v_r || out_free) begin
            if (hold_v_r) begin
              out_v_nxt            = 1'b1;
              out_nxt.out_bit      = hold_bit_r;
              out_nxt.follow_count = hold_cnt_r;
              out_nxt.last         = 1'b0;
            end
            hold_v_nxt   = 1'b1;
            hold_bit_nxt = high_r[REG_W-1];
            hold_cnt_nxt = pend_r;
            pend_nxt     = '0;
            high_nxt     = {high_r[REG_W-2:0], 1'b1};
            low_nxt      = {low_r[REG_W-2:0], 1'b0};
            nemit_nxt    = nemit_r + 1'b1;
          end
        end else if ((nemit_r != EMIT_W'(MAX_EMIT)) && strad_c) begin
          high_nxt = {high_r[REG_W-1], high_r[REG_W-3:0], 1'b1};
          low_nxt  = {low_r[REG_W-1], low_r[REG_W-3:0], 1'b0};
          pend_nxt = pend_bump(pend_r);
        end else begin
          // loop ends: the held bit is the last of this symbol
          if (!hold_v_r) begin
            state_nxt = S_IDLE;
          end else if (out_free) begin
            out_v_nxt            = 1'b1;
            out_nxt.out_bit      = hold_bit_r;
            out_nxt.follow_count = hold_cnt_r;
            out_nxt.last         = 1'b1;
            hold_v_nxt           = 1'b0;
            state_nxt            = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      high_r   <= TOP_MASK;
      low_r    <= '0;
      pend_r   <= '0;
      nemit_r  <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      high_r   <= high_nxt;
      low_r    <= low_nxt;
      pend_r   <= pend_nxt;
      nemit_r  <= nemit_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_bit_r <= hold_bit_nxt;
    hold_cnt_r <= hold_cnt_nxt;
    out_r      <= out_nxt;
    if (in_xfer) begin
      cl_r  <= {1'b0, in_data.cum_low};
      ch_r  <= in_data.cum_high;
      tot_r <= in_data.total;
      rng_r <= {1'b0, high_r} - {1'b0, low_r} + 1'b1;
    end
    if ((state_r == S_WTH) && div_done) begin
      qh_r <= div_q;
    end
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 32-bit binary arithmetic range encoder
//
// a queue of symbol and flush transfers feeds a clocked driver that sends in
// bursts with random gaps; a clocked monitor stalls on its own ready pattern
// and compares every result transfer, field by field, against code bits
// worked out by an in-bench copy of the interval arithmetic. stimulus covers
// the count extremes, invalid counts, middle-straddle pending bits, both flush
// bit choices and a long random stretch
// ----------------------------------------------------------------------------
module tb_top import ae32_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FREQ_BITS  = FREQ_BITS_DEF;
  localparam int HALF_CLK   = 6;
  localparam int RAND_ITEMS = 265;
  // extra time after the last expected result; allow stalls on up to 32 results
  localparam int DRAIN_CYC  = 400;
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int REPORT_CAP = 200;

  // one queued transfer plus a flag that holds it back until all results are in
  typedef struct {
    in_t data;
    bit  drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  stim_t symbol_q[$];
  out_t  expected_bits[$];
  stim_t head_item;

  // interval state as the bench sees it
  logic [REG_W-1:0]  iv_high = '1;
  logic [REG_W-1:0]  iv_low = '0;
  logic [PEND_W-1:0] pend_cnt = '0;

  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  logic [15:0] ready_pat = 16'hFFFF;
  logic [3:0]  ready_idx = '0;
  out_t        want;

  arithmetic_encoder_32bit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(HALF_CLK) clk = ~clk;

  // --------------------------------------------------------------------------
  // prediction: narrow the interval, renormalize, queue the emitted code bits
  // --------------------------------------------------------------------------
  function automatic void predict_code_bits(input in_t it);
    logic [63:0] span;
    logic [63:0] top_new;
    logic [63:0] bot_new;
    logic [63:0] c_lo;
    logic [63:0] c_hi;
    logic [63:0] tot;
    out_t        emitted[$];
    out_t        r;
    int          n;
    bit          busy;
    c_lo = {48'd0, it.cum_low};
    c_hi = {47'd0, it.cum_high};
    tot  = {47'd0, it.total};
    if (it.mode == MODE_FLUSH) begin
      // flush counts one more pending bit, then picks the quarter side of low
      if (pend_cnt != PEND_MAX) pend_cnt = pend_cnt + 1'b1;
      r.out_bit      = (iv_low < QUARTER) ? 1'b0 : 1'b1;
      r.follow_count = pend_cnt;
      r.last         = 1'b1;
      expected_bits.insert(expected_bits.size(), r);
      iv_high  = '1;
      iv_low   = '0;
      pend_cnt = '0;
      return;
    end
    // bad counts are dropped without touching the state
    if (tot == 0 || tot > (64'd1 << FREQ_BITS) || c_hi > tot || c_lo >= c_hi) return;
    span    = {32'd0, iv_high} - {32'd0, iv_low} + 64'd1;
    top_new = {32'd0, iv_low} + (span * c_hi) / tot - 64'd1;
    bot_new = {32'd0, iv_low} + (span * c_lo) / tot;
    iv_high = top_new[REG_W-1:0];
    iv_low  = bot_new[REG_W-1:0];
    n    = 0;
    busy = 1'b1;
    while (busy && n < MAX_EMIT) begin
      if (!iv_high[31] || iv_low[31]) begin
        // top bits agree: shift one out with the pending count
        r.out_bit      = iv_high[31];
        r.follow_count = pend_cnt;
        r.last         = 1'b0;
        emitted.insert(emitted.size(), r);
        pend_cnt = '0;
        iv_high  = {iv_high[30:0], 1'b1};
        iv_low   = {iv_low[30:0], 1'b0};
        n++;
      end else if (iv_high[31:30] == 2'b10 && iv_low[31:30] == 2'b01) begin
        // middle straddle: drop the second bit, keep the top one
        iv_high = {1'b1, iv_high[29:0], 1'b1};
        iv_low  = {1'b0, iv_low[29:0], 1'b0};
        if (pend_cnt != PEND_MAX) pend_cnt = pend_cnt + 1'b1;
      end else begin
        busy = 1'b0;
      end
    end
    if (emitted.size() > 0) emitted[emitted.size()-1].last = 1'b1;
    foreach (emitted[k]) expected_bits.insert(expected_bits.size(), emitted[k]);
  endfunction

  task automatic add_item(input logic m, input int cl, input int ch, input int tot,
                          input bit drain = 1'b0);
    stim_t s;
    s.data.mode     = m;
    s.data.cum_low  = cl[CL_W-1:0];
    s.data.cum_high = ch[CNT_W-1:0];
    s.data.total    = tot[CNT_W-1:0];
    s.drain         = drain;
    symbol_q.insert(symbol_q.size(), s);
  endtask

  task automatic report_mismatch(input string field, input int want_v, input int got_v);
    mismatch_count++;
    // keep the log short if the block goes badly wrong
    if (mismatch_count <= REPORT_CAP)
      $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of transfers with random gaps, optional hold until drained
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_code_bits(in_data);
      if (in_valid && !in_ready) begin
        // hold the payload until the transfer happens
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (symbol_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (symbol_q[0].drain && expected_bits.size() != 0) begin
        // pause until every outstanding code bit has come back
        in_valid <= 1'b0;
      end else begin
        head_item = symbol_q.pop_front();
        in_data  <= head_item.data;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          // a third of the bursts run back to back with no gap
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check each result transfer, stall on a 16-bit ready pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bits.size() == 0) begin
          report_mismatch("unexpected out_bit", -1, out_data.out_bit);
        end else begin
          want = expected_bits.pop_front();
          if (out_data.out_bit !== want.out_bit)
            report_mismatch("out_bit", want.out_bit, out_data.out_bit);
          if (out_data.follow_count !== want.follow_count)
            report_mismatch("follow_count", want.follow_count, out_data.follow_count);
          if (out_data.last !== want.last)
            report_mismatch("last", want.last, out_data.last);
        end
      end
      out_ready <= ready_pat[ready_idx];
      ready_idx <= ready_idx + 1'b1;
      // now and then switch to a new pattern, sometimes one with no stall
      if (ready_idx == 4'hF && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 2) == 0) ready_pat <= 16'hFFFF;
        else ready_pat <= 16'($urandom_range(1, 16'hFFFF));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int real_items;
    int kind;
    int sub;
    int cl;
    int ch;
    int tot;
    int d;

    // directed: flush right after reset, low below a quarter
    add_item(MODE_FLUSH, 0, 0, 0);
    // single-symbol model and full-range symbol: no bit emitted
    add_item(MODE_ENCODE, 0, 1, 1);
    add_item(MODE_ENCODE, 0, 65536, 65536);
    // narrowest symbols at the top and the bottom of the range
    add_item(MODE_ENCODE, 65535, 65536, 65536);
    add_item(MODE_ENCODE, 0, 1, 65536);
    // invalid counts: zero total, total too big, cum_high above total,
    // cum_low equal to and above cum_high
    add_item(MODE_ENCODE, 0, 1, 0);
    add_item(MODE_ENCODE, 0, 1, 65537);
    add_item(MODE_ENCODE, 65535, 131071, 131071);
    add_item(MODE_ENCODE, 0, 5, 4);
    add_item(MODE_ENCODE, 3, 3, 8);
    add_item(MODE_ENCODE, 7, 2, 8);
    // two middle straddles, then a bit that carries both pending copies
    add_item(MODE_ENCODE, 1, 3, 4);
    add_item(MODE_ENCODE, 1, 3, 4);
    add_item(MODE_ENCODE, 0, 1, 2);
    // low at exactly a quarter, then flush with junk fields: flush bit is one
    add_item(MODE_ENCODE, 1, 4, 4);
    add_item(MODE_FLUSH, 65535, 131071, 131071);
    // back-to-back flush
    add_item(MODE_FLUSH, 0, 0, 0);
    // deep straddle: fifteen pending bits in one symbol
    add_item(MODE_ENCODE, 32767, 32769, 65536);
    add_item(MODE_ENCODE, 1, 2, 2);
    add_item(MODE_ENCODE, 0, 1, 2);
    add_item(MODE_FLUSH, 0, 0, 0, 1'b1);

    // random: mostly valid symbols, some middle ones, flushes and noise
    real_items = 0;
    while (real_items < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        add_item(MODE_FLUSH, $urandom_range(0, 65535), $urandom_range(0, 131071),
                 $urandom_range(0, 131071), (real_items % 60) == 0);
        real_items++;
      end else if (kind < 14) begin
        sub = $urandom_range(0, 3);
        case (sub)
          0: begin
            tot = 0;
            ch  = $urandom_range(0, 131071);
            cl  = $urandom_range(0, 65535);
          end
          1: begin
            tot = $urandom_range(65537, 131071);
            ch  = $urandom_range(0, 131071);
            cl  = $urandom_range(0, 65535);
          end
          2: begin
            tot = $urandom_range(1, 65536);
            ch  = $urandom_range(tot + 1, 131071);
            cl  = $urandom_range(0, 65535);
          end
          default: begin
            tot = $urandom_range(1, 65536);
            cl  = $urandom_range(0, 65535);
            ch  = $urandom_range(0, (cl < tot) ? cl : tot);
          end
        endcase
        add_item(MODE_ENCODE, cl, ch, tot);
      end else if (kind < 26) begin
        // symbol around the midpoint, builds up pending bits
        d = $urandom_range(1, 16384);
        add_item(MODE_ENCODE, 32768 - d, 32768 + d, 65536, (real_items % 60) == 0);
        real_items++;
      end else begin
        sub = $urandom_range(0, 3);
        case (sub)
          0: tot = $urandom_range(1, 65536);
          1: tot = $urandom_range(1, 16);
          2: tot = 1 << $urandom_range(0, FREQ_BITS);
          default: tot = 65536;
        endcase
        ch = $urandom_range(1, tot);
        cl = $urandom_range(0, ch - 1);
        add_item(MODE_ENCODE, cl, ch, tot, (real_items % 60) == 0);
        real_items++;
      end
    end

    // close the stream from a drained state
    add_item(MODE_FLUSH, 0, 0, 0, 1'b1);
    add_item(MODE_ENCODE, 0, 1, 2);
    add_item(MODE_FLUSH, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (symbol_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_bits.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_count == 0 && expected_bits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
